[hdl/htq_pkg.sv]
// Shared types and constants for the heightmap triangle height query unit.
package htq_pkg;

  // Field and register widths fixed by the interface
  localparam int unsigned CFG_W     = 9;
  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned INDEX_W   = 16;
  localparam int unsigned POS_W     = 17;
  localparam int unsigned HEIGHT_W  = 14;
  localparam int unsigned APB_W     = 32;
  localparam int unsigned PADDR_W   = 3;

  // Reset value of both grid size registers
  localparam logic [CFG_W-1:0] GRID_RESET = 9'd256;

  // Register indexes, decoded from paddr[2]
  localparam logic REG_GRID_WIDTH = 1'b0;
  localparam logic REG_GRID_DEPTH = 1'b1;

  // Operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_BASE  = 12'b0000_0000_0010,
    ST_RD0   = 12'b0000_0000_0100,
    ST_RD1   = 12'b0000_0000_1000,
    ST_RD2   = 12'b0000_0001_0000,
    ST_RD3   = 12'b0000_0010_0000,
    ST_LOAD  = 12'b0000_0100_0000,
    ST_MAC0  = 12'b0000_1000_0000,
    ST_MAC1  = 12'b0001_0000_0000,
    ST_ACCUM = 12'b0010_0000_0000,
    ST_DIV   = 12'b0100_0000_0000,
    ST_FIX   = 12'b1000_0000_0000
  } htq_state_e;

endpackage

[hdl/heightmap_triangle_height_query_unit.sv]
// Top level: heightmap sample store and triangle height query sequencer.
//
// Usage:
//   Items enter on start while busy is low. op_i = write stores write_height_i
//   at write_index_i and returns nothing. op_i = query returns one
//   beat on result_valid_o with in_range_o and height_value_o.
//   A query outside the grid returns its invalid beat the cycle after accept
//   and busy never rises. An in-range query holds busy through one multiply for
//   the cell base address, four reads through the single read port of the
//   sample memory, two multiply-accumulate passes and a reciprocal multiply
//   with one correction step for the divide by five, all on one shared
//   multiplier, and returns its beat as busy falls. The next item may be started
//   in the cycle that shows the result beat. Each result beat lasts exactly one
//   cycle; the receiver cannot stall it. Grid width and depth are written over
//   the APB port while idle, a rule for the user that the block does not
//   enforce. Reset returns both grid sizes to 256 and the sequencer to idle;
//   the sample memory is not cleared and must be written before it is queried.
module heightmap_triangle_height_query_unit
  import htq_pkg::*;
#(
  parameter int unsigned MAX_GRID_SIDE = 256,
  parameter int unsigned FRAC_BITS     = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // command channel
  input  logic                       start,
  output logic                       busy,
  input  logic                       op_i,
  input  logic [INDEX_W-1:0]         write_index_i,
  input  logic [SAMPLE_W-1:0]        write_height_i,
  input  logic signed [POS_W-1:0]    pos_x_i,
  input  logic signed [POS_W-1:0]    pos_z_i,
  // result channel
  output logic                       result_valid_o,
  output logic                       in_range_o,
  output logic [HEIGHT_W-1:0]        height_value_o,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [APB_W-1:0]           pwdata,
  output logic [APB_W-1:0]           prdata,
  output logic                       pready
);

  // derived sizes
  localparam int unsigned STORE_DEPTH = MAX_GRID_SIDE * MAX_GRID_SIDE;
  localparam int unsigned AW          = $clog2(STORE_DEPTH);
  localparam int unsigned SIDE_W      = $clog2(MAX_GRID_SIDE + 1);
  localparam int unsigned IX_W        = POS_W - FRAC_BITS;
  localparam int unsigned ACC_W       = SAMPLE_W + FRAC_BITS;
  localparam int unsigned AS_W        = ACC_W + 2;
  localparam int unsigned MW          = ((ACC_W > SIDE_W) ? ACC_W : SIDE_W) + 1;
  localparam int unsigned KSH         = ACC_W + 2;
  localparam int unsigned RW          = ACC_W + 3;
  localparam logic [ACC_W-1:0] RECIP  = ACC_W'((64'd1 << KSH) / 64'd5);
  localparam logic [FRAC_BITS:0] ONE  = (FRAC_BITS+1)'(1) << FRAC_BITS;

  htq_state_e state_q, state_d;

  logic [CFG_W-1:0]     width_q, depth_q;
  logic [SIDE_W-1:0]    w_c, d_c;
  logic                 accept, cfg_wr;

  logic [IX_W-1:0]      ix_in, iz_in;
  logic [FRAC_BITS-1:0] fx_in, fz_in;
  logic                 q_ok;

  logic [IX_W-1:0]      ix_q, iz_q;
  logic [FRAC_BITS-1:0] fx_q, fz_q;
  logic                 upper_q;

  logic [AW-1:0]        base_q, base_d;
  logic [AW-1:0]        raddr;
  logic                 st_we;
  logic [SAMPLE_W-1:0]  rdata;
  logic [SAMPLE_W-1:0]  h0_q, h1_q, h2_q, h3_q;

  logic signed [AS_W-1:0] acc_q, acc_d;
  logic [ACC_W-1:0]       acc_pos;

  logic                    mul_en;
  logic signed [MW-1:0]    mul_a, mul_b;
  logic signed [2*MW-1:0]  prod;

  logic signed [SAMPLE_W:0] diff_a, diff_b;
  logic [FRAC_BITS:0]       coef_a, coef_b;
  logic [SAMPLE_W-1:0]      h_base;

  logic [ACC_W-1:0] q0, q_fix;
  logic [RW-1:0]    rem;

  logic                 res_vld_q, res_vld_d;
  logic                 in_rng_q, in_rng_d;
  logic [HEIGHT_W-1:0]  hv_q, hv_d;

  // handshakes
  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= GRID_RESET;
      depth_q <= GRID_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_GRID_WIDTH) begin
        width_q <= pwdata[CFG_W-1:0];
      end else begin
        depth_q <= pwdata[CFG_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_GRID_DEPTH) ? APB_W'(depth_q) : APB_W'(width_q);

  // sizes above the store side act as the store side
  assign w_c = (32'(width_q) > 32'(MAX_GRID_SIDE)) ? SIDE_W'(MAX_GRID_SIDE) : SIDE_W'(width_q);
  assign d_c = (32'(depth_q) > 32'(MAX_GRID_SIDE)) ? SIDE_W'(MAX_GRID_SIDE) : SIDE_W'(depth_q);

  // split the position and check that it lies inside a cell
  assign ix_in = pos_x_i[POS_W-1:FRAC_BITS];
  assign iz_in = pos_z_i[POS_W-1:FRAC_BITS];
  assign fx_in = pos_x_i[FRAC_BITS-1:0];
  assign fz_in = pos_z_i[FRAC_BITS-1:0];
  assign q_ok  = !pos_x_i[POS_W-1] && !pos_z_i[POS_W-1]
              && (32'(ix_in) + 32'd2 <= 32'(w_c))
              && (32'(iz_in) + 32'd2 <= 32'(d_c));

  // capture query operands on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ix_q    <= ix_in;
      iz_q    <= iz_in;
      fx_q    <= fx_in;
      fz_q    <= fz_in;
      upper_q <= ((FRAC_BITS+1)'(fx_in) + (FRAC_BITS+1)'(fz_in)) > ONE;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept && (op_i == OP_QUERY) && q_ok) state_d = ST_BASE;
      ST_BASE:  state_d = ST_RD0;
      ST_RD0:   state_d = ST_RD1;
      ST_RD1:   state_d = ST_RD2;
      ST_RD2:   state_d = ST_RD3;
      ST_RD3:   state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_MAC0;
      ST_MAC0:  state_d = ST_MAC1;
      ST_MAC1:  state_d = ST_ACCUM;
      ST_ACCUM: state_d = ST_DIV;
      ST_DIV:   state_d = ST_FIX;
      ST_FIX:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // read address walk over the four cell corners
  assign base_d = prod[AW-1:0] + AW'(ix_q);
  always_comb begin
    case (state_q)
      ST_RD0:  raddr = base_d;
      ST_RD1:  raddr = base_q + AW'(1);
      ST_RD2:  raddr = base_q + AW'(w_c);
      ST_RD3:  raddr = base_q + AW'(w_c) + AW'(1);
      default: raddr = base_q;
    endcase
  end

  // sample capture as read data returns
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD0) base_q <= base_d;
    if (state_q == ST_RD1) h0_q <= rdata;
    if (state_q == ST_RD2) h2_q <= rdata;
    if (state_q == ST_RD3) h1_q <= rdata;
    if (state_q == ST_LOAD) h3_q <= rdata;
  end

  assign st_we = accept && (op_i == OP_WRITE) && (32'(write_index_i) < 32'(STORE_DEPTH));

  htq_store #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (AW'(write_index_i)),
    .wdata_i (write_height_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // triangle terms
  assign h_base = upper_q ? h3_q : h0_q;
  assign diff_a = upper_q ? ($signed({1'b0, h1_q}) - $signed({1'b0, h3_q}))
                          : ($signed({1'b0, h2_q}) - $signed({1'b0, h0_q}));
  assign diff_b = upper_q ? ($signed({1'b0, h2_q}) - $signed({1'b0, h3_q}))
                          : ($signed({1'b0, h1_q}) - $signed({1'b0, h0_q}));
  assign coef_a = upper_q ? (ONE - (FRAC_BITS+1)'(fx_q)) : (FRAC_BITS+1)'(fx_q);
  assign coef_b = upper_q ? (ONE - (FRAC_BITS+1)'(fz_q)) : (FRAC_BITS+1)'(fz_q);

  // clamped accumulator feeds the divide
  assign acc_pos = acc_q[AS_W-1] ? '0 : acc_q[ACC_W-1:0];

  // shared multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      ST_BASE: begin
        mul_a = MW'(iz_q);
        mul_b = MW'(w_c);
      end
      ST_MAC0: begin
        mul_a = MW'(diff_a);
        mul_b = MW'(coef_a);
      end
      ST_MAC1: begin
        mul_a = MW'(diff_b);
        mul_b = MW'(coef_b);
      end
      ST_DIV: begin
        mul_a = MW'(acc_pos);
        mul_b = MW'(RECIP);
      end
      default: mul_en = 1'b0;
    endcase
  end

  htq_mul #(
    .OP_W (MW)
  ) u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // accumulator
  always_comb begin
    acc_d = acc_q;
    case (state_q)
      ST_MAC0:  acc_d = $signed(AS_W'({h_base, {FRAC_BITS{1'b0}}}));
      ST_MAC1:  acc_d = acc_q + AS_W'(prod);
      ST_ACCUM: acc_d = acc_q + AS_W'(prod);
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // reciprocal quotient plus one correction step
  assign q0    = prod[KSH +: ACC_W];
  assign rem   = RW'(acc_pos) - (RW'(q0) << 2) - RW'(q0);
  assign q_fix = (rem >= RW'(5)) ? (q0 + ACC_W'(1)) : q0;

  // result register
  always_comb begin
    res_vld_d = 1'b0;
    in_rng_d  = in_rng_q;
    hv_d      = hv_q;
    if (state_q == ST_FIX) begin
      res_vld_d = 1'b1;
      in_rng_d  = 1'b1;
      hv_d      = HEIGHT_W'(q_fix);
    end else if (accept && (op_i == OP_QUERY) && !q_ok) begin
      res_vld_d = 1'b1;
      in_rng_d  = 1'b0;
      hv_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_rng_q <= in_rng_d;
    hv_q     <= hv_d;
  end

  assign result_valid_o = res_vld_q;
  assign in_range_o     = in_rng_q;
  assign height_value_o = hv_q;

endmodule

[hdl/htq_store.sv]
// Height sample memory: one write port, one registered read port.
module htq_store #(
  parameter int unsigned DEPTH  = 65536,
  parameter int unsigned ADDR_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/htq_mul.sv]
// Shared signed multiplier with a registered product.
module htq_mul #(
  parameter int unsigned OP_W = 25
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [OP_W-1:0]   a_i,
  input  logic signed [OP_W-1:0]   b_i,
  output logic signed [2*OP_W-1:0] prod_o
);

  logic signed [2*OP_W-1:0] prod_q;

  // product register, loaded when the sequencer issues an operation
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

[hdl/htq_checker.sv]
// Port-level checker for the height query unit, with its bind.
module htq_checker
  import htq_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic                    op_i,
  input logic signed [POS_W-1:0] pos_x_i,
  input logic signed [POS_W-1:0] pos_z_i,
  input logic                    result_valid_o,
  input logic                    in_range_o,
  input logic [HEIGHT_W-1:0]     height_value_o
);

  // a result beat only shows once the sequencer is back to idle
  a_beat_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result beat while busy");

  // an invalid beat carries a zero height
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !in_range_o) |-> (height_value_o == '0))
    else $error("invalid result with nonzero height");

  // a sample write returns no beat
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (op_i == OP_WRITE)) |=> !result_valid_o)
    else $error("result beat after a write");

  // a negative position answers invalid in the next cycle
  a_neg_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (op_i == OP_QUERY) && (pos_x_i[POS_W-1] || pos_z_i[POS_W-1]))
      |=> (result_valid_o && !in_range_o && !busy))
    else $error("negative position not rejected");

endmodule

bind heightmap_triangle_height_query_unit htq_checker u_htq_checker (.*);

[verif/heightmap_triangle_height_query_unit_tb.sv]
// Self-checking testbench for the heightmap triangle height query unit.
module testbench;
  import htq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_GRID_SIDE = 256;
  localparam int unsigned FRAC_BITS     = 8;
  localparam int          ONE           = 1 << FRAC_BITS;
  localparam int unsigned STORE_DEPTH   = MAX_GRID_SIDE * MAX_GRID_SIDE;
  localparam int unsigned NUM_PHASES    = 10;
  localparam int unsigned RANDOM_PER_PHASE = 70;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic                    op;
    logic [INDEX_W-1:0]      write_index;
    logic [SAMPLE_W-1:0]     write_height;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_z;
  } grid_cmd_t;

  typedef struct packed {
    logic                in_range;
    logic [HEIGHT_W-1:0] height;
  } height_beat_t;

  // DUT signals; the driven inputs are known from time zero
  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    start          = 1'b0;
  logic                    busy;
  logic                    op_i           = OP_WRITE;
  logic [INDEX_W-1:0]      write_index_i  = '0;
  logic [SAMPLE_W-1:0]     write_height_i = '0;
  logic signed [POS_W-1:0] pos_x_i        = '0;
  logic signed [POS_W-1:0] pos_z_i        = '0;
  logic                    result_valid_o;
  logic                    in_range_o;
  logic [HEIGHT_W-1:0]     height_value_o;
  logic                    psel           = 1'b0;
  logic                    penable        = 1'b0;
  logic                    pwrite         = 1'b0;
  logic [PADDR_W-1:0]      paddr          = '0;
  logic [APB_W-1:0]        pwdata         = '0;
  logic [APB_W-1:0]        prdata;
  logic                    pready;

  // Predictor state: sample store copy and grid size shadows
  bit   [SAMPLE_W-1:0] model_heights [STORE_DEPTH];
  bit                  sample_written [STORE_DEPTH];
  logic [CFG_W-1:0]    grid_width_q = GRID_RESET;
  logic [CFG_W-1:0]    grid_depth_q = GRID_RESET;

  grid_cmd_t    cmd_backlog [$];
  height_beat_t height_due [$];
  grid_cmd_t    cmd_now;
  bit           no_gaps      = 1'b0;
  int unsigned  idle_left    = 0;
  int unsigned  cmds_queued  = 0;
  int unsigned  cmds_taken   = 0;
  int unsigned  queries_seen = 0;
  int unsigned  hits_seen    = 0;
  int unsigned  error_count  = 0;
  int unsigned  cycle_count  = 0;

  int unsigned phase_w [NUM_PHASES] = '{256, 2, 3, 256, 17, 511, 0, 6, 100, 256};
  int unsigned phase_d [NUM_PHASES] = '{256, 2, 200, 2, 9, 300, 5, 1, 37, 256};

  heightmap_triangle_height_query_unit #(
    .MAX_GRID_SIDE(MAX_GRID_SIDE),
    .FRAC_BITS    (FRAC_BITS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .write_index_i (write_index_i),
    .write_height_i(write_height_i),
    .pos_x_i       (pos_x_i),
    .pos_z_i       (pos_z_i),
    .result_valid_o(result_valid_o),
    .in_range_o    (in_range_o),
    .height_value_o(height_value_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Sizes past the store act as the largest grid
  function automatic int grid_side(input logic [CFG_W-1:0] r);
    return (r > MAX_GRID_SIDE) ? MAX_GRID_SIDE : int'(r);
  endfunction

  // Cell lookup under the current grid sizes; 0 when outside every cell
  function automatic bit locate_cell(input logic signed [POS_W-1:0] x,
                                     input logic signed [POS_W-1:0] z,
                                     output int unsigned base, output int fx, output int fz);
    int px, pz, w, d, ix, iz;
    w    = grid_side(grid_width_q);
    d    = grid_side(grid_depth_q);
    px   = x;
    pz   = z;
    base = 0;
    fx   = 0;
    fz   = 0;
    if (px < 0 || pz < 0 || w < 2 || d < 2) return 1'b0;
    ix = px >>> FRAC_BITS;
    iz = pz >>> FRAC_BITS;
    if (ix > w - 2 || iz > d - 2) return 1'b0;
    fx   = px & (ONE - 1);
    fz   = pz & (ONE - 1);
    base = iz * w + ix;
    return 1'b1;
  endfunction

  // Apply one accepted command: store a sample or queue the expected height
  function automatic void predict_height(input grid_cmd_t c);
    height_beat_t beat;
    int unsigned  base;
    int           fx, fz, w, h0, h1, h2, h3, acc;
    if (c.op == OP_WRITE) begin
      model_heights[c.write_index] = c.write_height;
      return;
    end
    beat = '0;
    if (locate_cell(c.pos_x, c.pos_z, base, fx, fz)) begin
      w  = grid_side(grid_width_q);
      h0 = model_heights[base];
      h2 = model_heights[base + 1];
      h1 = model_heights[base + w];
      h3 = model_heights[base + w + 1];
      // lower triangle when fx + fz <= 1, else upper
      if (fx + fz <= ONE)
        acc = h0 * ONE + (h2 - h0) * fx + (h1 - h0) * fz;
      else
        acc = h3 * ONE + (h1 - h3) * (ONE - fx) + (h2 - h3) * (ONE - fz);
      beat.in_range = 1'b1;
      beat.height   = HEIGHT_W'(acc / 5);
    end
    height_due.push_back(beat);
  endfunction

  // Stimulus helpers; unused fields of a command carry random junk
  function automatic void write_sample(input int unsigned idx, input int unsigned value);
    grid_cmd_t c;
    c.op           = OP_WRITE;
    c.write_index  = INDEX_W'(idx);
    c.write_height = SAMPLE_W'(value);
    c.pos_x        = POS_W'($urandom);
    c.pos_z        = POS_W'($urandom);
    sample_written[c.write_index] = 1'b1;
    cmd_backlog.push_back(c);
    cmds_queued++;
  endfunction

  // Query; corners never written get a sample first
  function automatic void ask_height(input logic signed [POS_W-1:0] x,
                                     input logic signed [POS_W-1:0] z);
    grid_cmd_t   c;
    int unsigned base, w;
    int unsigned corner [4];
    int          fx, fz;
    if (locate_cell(x, z, base, fx, fz)) begin
      w = grid_side(grid_width_q);
      corner = '{base, base + 1, base + w, base + w + 1};
      foreach (corner[k])
        if (!sample_written[corner[k]]) write_sample(corner[k], $urandom_range(0, 255));
    end
    c.op           = OP_QUERY;
    c.write_index  = INDEX_W'($urandom);
    c.write_height = SAMPLE_W'($urandom);
    c.pos_x        = x;
    c.pos_z        = z;
    cmd_backlog.push_back(c);
    cmds_queued++;
  endfunction

  function automatic void queue_random();
    int w, d, r, ix, iz, fx, fz, lo_x, lo_z, span;
    logic signed [POS_W-1:0] x, z;
    w = grid_side(grid_width_q);
    d = grid_side(grid_depth_q);
    r = $urandom_range(0, 99);
    if (r < 20) begin
      write_sample($urandom_range(0, 65535), $urandom_range(0, 255));
    end else if (r < 30 && w >= 2 && d >= 2) begin
      write_sample($urandom_range(0, w * d - 1), $urandom_range(0, 255));
    end else if (r < 85 && w >= 2 && d >= 2) begin
      // in-range query, half of them packed near the origin for sample reuse
      if ($urandom_range(0, 1)) begin
        span = (w - 2 < 7) ? w - 2 : 7;
        ix   = $urandom_range(0, span);
        span = (d - 2 < 7) ? d - 2 : 7;
        iz   = $urandom_range(0, span);
      end else begin
        ix = $urandom_range(0, w - 2);
        iz = $urandom_range(0, d - 2);
      end
      fx = $urandom_range(0, ONE - 1);
      if ($urandom_range(0, 4) == 0 && fx != 0) fz = ONE - fx;
      else fz = $urandom_range(0, ONE - 1);
      ask_height(POS_W'(ix * ONE + fx), POS_W'(iz * ONE + fz));
    end else begin
      // mostly outside: negative, past the last cell, or anything at all
      lo_x = (w > 0) ? (w - 1) * ONE : 0;
      lo_z = (d > 0) ? (d - 1) * ONE : 0;
      x    = POS_W'($urandom_range(0, 65535));
      z    = POS_W'($urandom_range(0, 65535));
      case ($urandom_range(0, 4))
        0: x = POS_W'(-int'($urandom_range(1, 65536)));
        1: z = POS_W'(-int'($urandom_range(1, 65536)));
        2: x = POS_W'($urandom_range(lo_x, 65535));
        3: z = POS_W'($urandom_range(lo_z, 65535));
        default: begin
          x = POS_W'($urandom);
          z = POS_W'($urandom);
        end
      endcase
      ask_height(x, z);
    end
  endfunction

  function automatic int unsigned pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 14);
    return $urandom_range(15, 60);
  endfunction

  // Register write, then read back over the same port
  task automatic set_grid(input logic reg_sel, input int unsigned value);
    logic [APB_W-1:0] data;
    data            = $urandom;
    data[CFG_W-1:0] = value[CFG_W-1:0];
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == REG_GRID_WIDTH) grid_width_q = value[CFG_W-1:0];
    else grid_depth_q = value[CFG_W-1:0];
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== APB_W'(value[CFG_W-1:0])) begin
      $error("prdata: expected %0d, got %0d", value[CFG_W-1:0], prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Wait until every command is taken and every result is back
  task automatic drain();
    while (cmds_taken != cmds_queued || height_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Command driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_height(cmd_now);
        cmds_taken++;
      end
      if (!start || !busy) begin
        if (idle_left == 0 && cmd_backlog.size() != 0) begin
          cmd_now        = cmd_backlog.pop_front();
          start          <= 1'b1;
          op_i           <= cmd_now.op;
          write_index_i  <= cmd_now.write_index;
          write_height_i <= cmd_now.write_height;
          pos_x_i        <= cmd_now.pos_x;
          pos_z_i        <= cmd_now.pos_z;
          idle_left      = no_gaps ? 0 : pick_gap();
        end else begin
          if (idle_left != 0) idle_left--;
          start          <= 1'b0;
          op_i           <= 1'($urandom);
          write_index_i  <= INDEX_W'($urandom);
          write_height_i <= SAMPLE_W'($urandom);
          pos_x_i        <= POS_W'($urandom);
          pos_z_i        <= POS_W'($urandom);
        end
      end
    end
  end

  // Result monitor and run timeout
  always @(posedge clk_i) begin
    height_beat_t due;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL heightmap_triangle_height_query_unit");
      $finish;
    end else if (rst_ni && result_valid_o) begin
      if (height_due.size() == 0) begin
        $error("result beat with no query outstanding");
        error_count++;
      end else begin
        due = height_due.pop_front();
        queries_seen++;
        if (due.in_range) hits_seen++;
        if (in_range_o !== due.in_range) begin
          $error("in_range: expected %0d, got %0d", due.in_range, in_range_o);
          error_count++;
        end
        if (height_value_o !== due.height) begin
          $error("height_value: expected %0d, got %0d", due.height, height_value_o);
          error_count++;
        end
      end
    end
  end

  // Phase sequencing
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        set_grid(REG_GRID_WIDTH, phase_w[p]);
        set_grid(REG_GRID_DEPTH, phase_d[p]);
      end
      @(negedge clk_i);
      no_gaps = (p % 3 == 2);
      if (p == 0) begin
        // cell at the origin, distinct corners
        write_sample(0, 0);
        write_sample(1, 255);
        write_sample(256, 200);
        write_sample(257, 17);
        ask_height(0, 0);
        ask_height(255, 0);
        ask_height(0, 255);
        ask_height(128, 128);
        ask_height(129, 128);
        ask_height(255, 255);
        // last cell at full scale gives the largest height
        write_sample(65278, 255);
        write_sample(65279, 255);
        write_sample(65534, 255);
        write_sample(65535, 255);
        ask_height(65279, 65279);
        ask_height(65024, 65024);
        // just past the grid and negative positions
        ask_height(65280, 0);
        ask_height(0, 65280);
        ask_height(-1, 0);
        ask_height(0, -65536);
        ask_height(65535, 65535);
        ask_height(-65536, -1);
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) queue_random();
      drain();
    end
    $display("Ran %0d commands over %0d grid size settings, including zero, one and oversize.",
             cmds_taken, NUM_PHASES);
    $display("Checked %0d query results, %0d of them inside a grid cell.",
             queries_seen, hits_seen);
    if (error_count == 0 && height_due.size() == 0) begin
      $display("PASS heightmap_triangle_height_query_unit");
    end else begin
      $display("FAIL heightmap_triangle_height_query_unit");
    end
    $finish;
  end

endmodule
